// File: src/deq_pkg.sv
// Shared types and constants for the double-ended queue with value search.
// Used by the interfaces, the control unit and the top level.
package deq_pkg;

	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int KIND_W      = 3;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 3;
	localparam int POS_W       = 6;
	localparam int MATCH_W     = $clog2(MAX_RESULTS + 1);

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [MATCH_W-1:0] match_cnt_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INS_FRONT = 3'd0,
		KIND_INS_BACK  = 3'd1,
		KIND_REM_FRONT = 3'd2,
		KIND_REM_BACK  = 3'd3,
		KIND_SEARCH    = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FOUND    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		pos_t    position;
		logic    last;
	} res_t;

endpackage

// File: src/deq_req_if.sv
// Request channel of the queue: operation kind and value.
// Depends on deq_pkg.
interface deq_req_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::KIND_W-1:0]          kind;
	logic signed [deq_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

// File: src/deq_rsp_if.sv
// Response channel of the queue: status, match position and last flag.
// Depends on deq_pkg.
interface deq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [deq_pkg::STATUS_W-1:0]  status;
	logic [deq_pkg::POS_W-1:0]     position;
	logic                          last;

	modport source (output valid, output status, output position, output last, input ready);
	modport sink (input valid, input status, input position, input last, output ready);
endinterface

// File: src/deque_with_value_search.sv
// Top level of the bounded double-ended queue with value search.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_mem and deq_ctrl.
//
//   Channel  Role   Word
//   req      sink   kind, value
//   rsp      source status, position, last
//
// Inserts, removals and searches of an empty queue are answered on acceptance; the
// result is held in the output register from the next cycle on.
// A search reads the ring store once per live entry, and a new request is taken only
// after its final word. A stalled response holds the scan in place only while a found
// position or the final word waits to be sent; the store needs no clearing pass.
// Reset clears the front index and entry count; entries are undefined until written.
module deque_with_value_search #(
	parameter int DEPTH = deq_pkg::DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(DEPTH);

	deq_pkg::res_t                 res;
	deq_pkg::res_t                 out_q;
	logic                          out_free;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic [deq_pkg::VALUE_W-1:0]   wr_data;
	logic                          rd_en;
	logic [IDX_W-1:0]              rd_addr;
	logic [deq_pkg::VALUE_W-1:0]   rd_data;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.out_free(out_free),
		.res     (res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	deq_mem #(
		.DEPTH(DEPTH),
		.WIDTH(deq_pkg::VALUE_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign out_free = !out_q.valid || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (res.valid) begin
			out_q <= res;
		end else if (rsp.ready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign rsp.valid    = out_q.valid;
	assign rsp.status   = out_q.status;
	assign rsp.position = out_q.position;
	assign rsp.last     = out_q.last;

endmodule

// File: src/deq_mem.sv
// Ring store of the queue entries: one write port and one registered read port.
// No dependencies.
module deq_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/deq_ctrl.sv
// Queue control: front index, entry count, operation decode and the search scan.
// Depends on deq_pkg and deq_req_if; drives the ring store ports.
module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	deq_req_if.sink                       req,
	input  logic                          out_free,
	output deq_pkg::res_t                 res,
	output logic                          wr_en,
	output logic [IDX_W-1:0]              wr_addr,
	output logic [deq_pkg::VALUE_W-1:0]   wr_data,
	output logic                          rd_en,
	output logic [IDX_W-1:0]              rd_addr,
	input  logic [deq_pkg::VALUE_W-1:0]   rd_data
);

	localparam int SUM_W = CNT_W + 1;

	deq_pkg::state_t           state_q, state_d;
	logic [IDX_W-1:0]          front_q, front_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          idx_q, idx_d;
	logic [IDX_W-1:0]          ptr_q, ptr_d;
	deq_pkg::match_cnt_t       n_q, n_d;
	logic                      pend_valid_q, pend_valid_d;
	deq_pkg::pos_t             pend_pos_q, pend_pos_d;
	logic                      valid_s2, valid_s2_d;
	logic [CNT_W-1:0]          pos_s2, pos_s2_d;
	logic [deq_pkg::VALUE_W-1:0] val_q, val_d;

	logic [SUM_W-1:0]          back_sum;
	logic [IDX_W-1:0]          back_addr;
	logic [IDX_W-1:0]          front_dec;
	logic [IDX_W-1:0]          front_inc;
	logic [IDX_W-1:0]          ptr_inc;
	logic                      is_full;
	logic                      is_empty;
	logic                      match;
	logic                      advance;
	logic                      more;
	logic                      scan_done;

	always_comb begin
		back_sum = SUM_W'(count_q) + SUM_W'(front_q);
		if (back_sum >= SUM_W'(DEPTH)) begin
			back_sum = back_sum - SUM_W'(DEPTH);
		end
		back_addr = IDX_W'(back_sum);
		front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
		front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
		ptr_inc   = (ptr_q == IDX_W'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
		is_full   = (count_q == CNT_W'(DEPTH));
		is_empty  = (count_q == '0);
		match     = valid_s2 && (rd_data == val_q) &&
			(n_q < deq_pkg::match_cnt_t'(deq_pkg::MAX_RESULTS));
		advance   = !(match && pend_valid_q) || out_free;
		more      = (idx_q < count_q) &&
			(n_q < deq_pkg::match_cnt_t'(deq_pkg::MAX_RESULTS));
		scan_done = !valid_s2 && !more;
	end

	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		count_d      = count_q;
		idx_d        = idx_q;
		ptr_d        = ptr_q;
		n_d          = n_q;
		pend_valid_d = pend_valid_q;
		pend_pos_d   = pend_pos_q;
		valid_s2_d   = valid_s2;
		pos_s2_d     = pos_s2;
		val_d        = val_q;
		res          = '0;
		req.ready    = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = front_dec;
		wr_data      = req.value;
		rd_en        = 1'b0;
		rd_addr      = ptr_q;

		case (state_q)
			deq_pkg::S_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					res.valid    = 1'b1;
					res.last     = 1'b1;
					res.position = '0;
					res.status   = deq_pkg::ST_DONE;
					case (deq_pkg::kind_t'(req.kind))
						deq_pkg::KIND_INS_FRONT: begin
							if (is_full) begin
								res.status = deq_pkg::ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = front_dec;
								front_d = front_dec;
								count_d = count_q + 1'b1;
							end
						end
						deq_pkg::KIND_INS_BACK: begin
							if (is_full) begin
								res.status = deq_pkg::ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = back_addr;
								count_d = count_q + 1'b1;
							end
						end
						deq_pkg::KIND_REM_FRONT: begin
							if (is_empty) begin
								res.status = deq_pkg::ST_EMPTY;
							end else begin
								front_d = front_inc;
								count_d = count_q - 1'b1;
							end
						end
						deq_pkg::KIND_REM_BACK: begin
							if (is_empty) begin
								res.status = deq_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						deq_pkg::KIND_SEARCH: begin
							if (is_empty) begin
								res.status = deq_pkg::ST_EMPTY;
							end else begin
								res.valid    = 1'b0;
								state_d      = deq_pkg::S_SCAN;
								idx_d        = '0;
								ptr_d        = front_q;
								n_d          = '0;
								pend_valid_d = 1'b0;
								valid_s2_d   = 1'b0;
								val_d        = req.value;
							end
						end
						default: begin
							res.status = deq_pkg::ST_DONE;
						end
					endcase
				end
			end
			deq_pkg::S_SCAN: begin
				if (scan_done) begin
					if (out_free) begin
						res.valid = 1'b1;
						res.last  = 1'b1;
						if (pend_valid_q) begin
							res.status   = deq_pkg::ST_FOUND;
							res.position = pend_pos_q;
						end else begin
							res.status   = deq_pkg::ST_NOTFOUND;
							res.position = '0;
						end
						pend_valid_d = 1'b0;
						state_d      = deq_pkg::S_IDLE;
					end
				end else if (advance) begin
					if (match) begin
						if (pend_valid_q) begin
							res.valid    = 1'b1;
							res.last     = 1'b0;
							res.status   = deq_pkg::ST_FOUND;
							res.position = pend_pos_q;
						end
						pend_valid_d = 1'b1;
						pend_pos_d   = deq_pkg::pos_t'(pos_s2);
						n_d          = n_q + 1'b1;
					end
					rd_en      = more;
					valid_s2_d = more;
					if (more) begin
						pos_s2_d = idx_q + 1'b1;
						idx_d    = idx_q + 1'b1;
						ptr_d    = ptr_inc;
					end
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= deq_pkg::S_IDLE;
			front_q      <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			ptr_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			state_q      <= state_d;
			front_q      <= front_d;
			count_q      <= count_d;
			idx_q        <= idx_d;
			ptr_q        <= ptr_d;
			n_q          <= n_d;
			pend_valid_q <= pend_valid_d;
			valid_s2     <= valid_s2_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_pos_q <= pend_pos_d;
		pos_s2     <= pos_s2_d;
		val_q      <= val_d;
	end

endmodule
